### rtl/mvcs_pkg.sv
// Package for the streaming column-sum block: shared widths, defaults and the
// per-item tag that travels from the multiply stage to the accumulator ring.
// No dependencies.
package mvcs_pkg;

    localparam int SIZE_REG_BITS    = 7;
    localparam int SUM_BITS         = 38;
    localparam int MAX_SIZE_DEF     = 64;
    localparam int ELEMENT_BITS_DEF = 16;
    localparam int SIZE_RESET       = 64;

    typedef struct packed {
        logic first_row;
        logic last_row;
        logic last_col;
    } tag_t;

endpackage

### rtl/mvcs_cell.sv
// One accumulator cell of the circulating column ring.
// Depends on mvcs_pkg for the sum width.
module mvcs_cell (
    input  logic                          clk,
    input  logic                          shift,
    input  logic                          is_tail,
    input  logic [mvcs_pkg::SUM_BITS-1:0] from_next,
    input  logic [mvcs_pkg::SUM_BITS-1:0] from_adder,
    output logic [mvcs_pkg::SUM_BITS-1:0] acc
);
    import mvcs_pkg::*;

    logic [SUM_BITS-1:0] acc_reg;
    logic [SUM_BITS-1:0] acc_next;

    always_comb
    begin
        acc_next = is_tail ? from_adder : from_next;
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

### rtl/mvcs_front.sv
// Input stage: size register, row and column counters and the registered
// multiplier. Depends on mvcs_pkg for the tag type and register widths.
module mvcs_front #(
    parameter int MAX_SIZE     = mvcs_pkg::MAX_SIZE_DEF,
    parameter int ELEMENT_BITS = mvcs_pkg::ELEMENT_BITS_DEF,
    parameter int INDEX_BITS   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1,
    parameter int COUNT_BITS   = $clog2(MAX_SIZE + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [mvcs_pkg::SIZE_REG_BITS-1:0] size_in_use,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [ELEMENT_BITS-1:0]     matrix_value,
    input  logic signed [ELEMENT_BITS-1:0]     vector_value,
    input  logic                               s1_take,
    output logic                               s1_valid,
    output mvcs_pkg::tag_t                     s1_tag,
    output logic [INDEX_BITS-1:0]              s1_index,
    output logic signed [2*ELEMENT_BITS-1:0]   s1_prod,
    output logic [COUNT_BITS-1:0]              size
);
    import mvcs_pkg::*;

    localparam int RESET_N = (SIZE_RESET > MAX_SIZE) ? MAX_SIZE : SIZE_RESET;

    logic [COUNT_BITS-1:0]            size_reg;
    logic [COUNT_BITS-1:0]            size_next;
    logic [INDEX_BITS-1:0]            col_reg;
    logic [INDEX_BITS-1:0]            col_next;
    logic [INDEX_BITS-1:0]            row_reg;
    logic [INDEX_BITS-1:0]            row_next;
    logic                             valid_reg;
    logic                             valid_next;
    tag_t                             tag_reg;
    tag_t                             tag_cur;
    logic [INDEX_BITS-1:0]            index_reg;
    logic signed [2*ELEMENT_BITS-1:0] prod_reg;
    logic                             accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = !valid_reg || s1_take;

    always_comb
    begin
        size_next = size_reg;
        if (cfg_valid)
        begin
            if (size_in_use == '0)
            begin
                size_next = COUNT_BITS'(1);
            end
            else if (int'(size_in_use) > MAX_SIZE)
            begin
                size_next = COUNT_BITS'(MAX_SIZE);
            end
            else
            begin
                size_next = COUNT_BITS'(size_in_use);
            end
        end
    end

    always_comb
    begin
        tag_cur.first_row = (row_reg == '0);
        tag_cur.last_row  = ((COUNT_BITS'(row_reg) + COUNT_BITS'(1)) == size_reg);
        tag_cur.last_col  = ((COUNT_BITS'(col_reg) + COUNT_BITS'(1)) == size_reg);

        col_next = col_reg;
        row_next = row_reg;
        if (cfg_valid)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (tag_cur.last_col)
            begin
                col_next = '0;
                row_next = tag_cur.last_row ? '0 : row_reg + INDEX_BITS'(1);
            end
            else
            begin
                col_next = col_reg + INDEX_BITS'(1);
            end
        end

        valid_next = accept ? 1'b1 : (s1_take ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= COUNT_BITS'(RESET_N);
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            size_reg  <= size_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tag_reg   <= tag_cur;
            index_reg <= col_reg;
            prod_reg  <= matrix_value * vector_value;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_tag   = tag_reg;
    assign s1_index = index_reg;
    assign s1_prod  = prod_reg;
    assign size     = size_reg;

    property p_cfg_restarts;
        @(posedge clk) disable iff (!rst_n)
        cfg_valid |=> (col_reg == '0) && (row_reg == '0);
    endproperty
    a_cfg_restarts: assert property (p_cfg_restarts)
        else $error("counters not restarted by a size write");

    property p_col_in_range;
        @(posedge clk) disable iff (!rst_n)
        !cfg_valid && accept |=> (COUNT_BITS'(col_reg) < size_reg);
    endproperty
    a_col_in_range: assert property (p_col_in_range)
        else $error("column counter beyond matrix size");

endmodule

### rtl/matrix_vector_column_sums.sv
// Top level of the streaming transposed matrix-vector product.
// Depends on mvcs_pkg, mvcs_front and mvcs_cell.
//
// Channel   Handshake             Payload
// cfg       cfg_valid/cfg_ready   size_in_use
// in        in_valid/in_ready     matrix_value, vector_value
// out       out_valid/out_ready   column_index, column_sum, last_column
//
// One item is taken per cycle unless stalled; any result it gives is registered.
// The column accumulators sit in a ring of MAX_SIZE cells that rotates by one
// on every item, so the head cell always holds the column being summed.
// Reset clears counters, sets size to min(64, MAX_SIZE); ring needs no clearing.
// A held result stalls input only when the next item also produces a result.
module matrix_vector_column_sums #(
    parameter int MAX_SIZE     = mvcs_pkg::MAX_SIZE_DEF,
    parameter int ELEMENT_BITS = mvcs_pkg::ELEMENT_BITS_DEF,
    parameter int INDEX_BITS   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mvcs_pkg::SIZE_REG_BITS-1:0] size_in_use,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [ELEMENT_BITS-1:0]     matrix_value,
    input  logic signed [ELEMENT_BITS-1:0]     vector_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [INDEX_BITS-1:0]              column_index,
    output logic signed [mvcs_pkg::SUM_BITS-1:0] column_sum,
    output logic                               last_column
);
    import mvcs_pkg::*;

    localparam int COUNT_BITS = $clog2(MAX_SIZE + 1);

    logic                             s1_valid;
    logic                             s1_take;
    tag_t                             s1_tag;
    logic [INDEX_BITS-1:0]            s1_index;
    logic signed [2*ELEMENT_BITS-1:0] s1_prod;
    logic [COUNT_BITS-1:0]            size;
    logic signed [SUM_BITS-1:0]       prod_ext;
    logic signed [SUM_BITS-1:0]       sum;
    logic [SUM_BITS-1:0]              ring [MAX_SIZE];

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [INDEX_BITS-1:0]            column_index_reg;
    logic signed [SUM_BITS-1:0]       column_sum_reg;
    logic                             last_column_reg;

    assign cfg_ready = 1'b1;

    mvcs_front #(
        .MAX_SIZE     (MAX_SIZE),
        .ELEMENT_BITS (ELEMENT_BITS),
        .INDEX_BITS   (INDEX_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .size_in_use  (size_in_use),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .matrix_value (matrix_value),
        .vector_value (vector_value),
        .s1_take      (s1_take),
        .s1_valid     (s1_valid),
        .s1_tag       (s1_tag),
        .s1_index     (s1_index),
        .s1_prod      (s1_prod),
        .size         (size)
    );

    assign s1_take  = s1_valid && (!s1_tag.last_row || !out_valid_reg || out_ready);
    assign prod_ext = SUM_BITS'(s1_prod);
    assign sum      = s1_tag.first_row ? prod_ext : ($signed(ring[0]) + prod_ext);

    for (genvar k = 0; k < MAX_SIZE; k++)
    begin : g_ring
        logic [SUM_BITS-1:0] from_next;
        if (k == MAX_SIZE - 1)
        begin : g_end
            assign from_next = sum;
        end
        else
        begin : g_mid
            assign from_next = ring[k+1];
        end

        mvcs_cell u_cell (
            .clk        (clk),
            .shift      (s1_take),
            .is_tail    (size == COUNT_BITS'(k + 1)),
            .from_next  (from_next),
            .from_adder (sum),
            .acc        (ring[k])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_take && s1_tag.last_row)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take && s1_tag.last_row)
        begin
            column_index_reg <= s1_index;
            column_sum_reg   <= sum;
            last_column_reg  <= s1_tag.last_col;
        end
    end

    assign out_valid    = out_valid_reg;
    assign column_index = column_index_reg;
    assign column_sum   = column_sum_reg;
    assign last_column  = last_column_reg;

    property p_result_loaded;
        @(posedge clk) disable iff (!rst_n)
        s1_take && s1_tag.last_row |=> out_valid_reg;
    endproperty
    a_result_loaded: assert property (p_result_loaded)
        else $error("finished column sum not presented");

    property p_no_overwrite;
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !(s1_take && s1_tag.last_row);
    endproperty
    a_no_overwrite: assert property (p_no_overwrite)
        else $error("held result overwritten");

    property p_no_spurious;
        @(posedge clk) disable iff (!rst_n)
        s1_take && !s1_tag.last_row && !out_valid_reg |=> !out_valid_reg;
    endproperty
    a_no_spurious: assert property (p_no_spurious)
        else $error("result raised by an item of an inner row");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for matrix_vector_column_sums: streams matrices, predicts each
// column sum and compares every result item. Depends on mvcs_pkg and the block's RTL.
module tb_top;

    localparam int  EW          = mvcs_pkg::ELEMENT_BITS_DEF;
    localparam int  SW          = mvcs_pkg::SUM_BITS;
    localparam int  SRB         = mvcs_pkg::SIZE_REG_BITS;
    localparam int  NMAX        = mvcs_pkg::MAX_SIZE_DEF;
    localparam int  IW          = (NMAX > 1) ? $clog2(NMAX) : 1;
    localparam real CLK_PERIOD  = 12.0;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  SETTLE_CYCLES = 6;
    localparam int  RANDOM_ITEMS  = 1300;
    localparam int  EXTREME_SIZE  = 16;

    typedef logic signed [EW-1:0] elem_t;

    typedef struct {
        elem_t matrix_v;
        elem_t vector_v;
        bit    hold_drain;
    } element_item_t;

    typedef struct {
        logic [IW-1:0]        idx;
        logic signed [SW-1:0] sum;
        logic                 last;
    } column_result_t;

    localparam elem_t ELEM_MIN = {1'b1, {(EW-1){1'b0}}};
    localparam elem_t ELEM_MAX = {1'b0, {(EW-1){1'b1}}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [SRB-1:0] size_in_use = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    elem_t matrix_value = '0;
    elem_t vector_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [IW-1:0] column_index;
    logic signed [SW-1:0] column_sum;
    logic last_column;

    element_item_t  feed_q[$];
    column_result_t pending_sums[$];

    logic signed [SW-1:0] col_acc [NMAX];
    logic [SRB-1:0] size_reg = SRB'(mvcs_pkg::SIZE_RESET);
    int unsigned row_pos = 0;
    int unsigned col_pos = 0;

    int unsigned items_issued = 0;
    int unsigned items_taken = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;

    matrix_vector_column_sums i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .size_in_use  (size_in_use),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .matrix_value (matrix_value),
        .vector_value (vector_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .column_index (column_index),
        .column_sum   (column_sum),
        .last_column  (last_column)
    );

    always #(CLK_PERIOD / 2.0) clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int unsigned eff_size(input logic [SRB-1:0] v);
        if (v == 0)
            return 1;
        if (v > NMAX)
            return NMAX;
        return v;
    endfunction

    // Multiply-accumulate into the current column; on the last row the finished sum is queued.
    task automatic accumulate_column(input elem_t m, input elem_t v);
        int unsigned n;
        int unsigned i;
        int unsigned j;
        logic signed [SW-1:0] product;
        column_result_t r;
        n = eff_size(size_reg);
        i = col_pos;
        j = row_pos;
        if (i >= n)
            i = 0;
        if (j >= n)
            j = 0;
        product = m * v;
        if (j == 0)
            col_acc[i] = product;
        else
            col_acc[i] = col_acc[i] + product;
        if (j == n - 1)
        begin
            r.idx  = IW'(i);
            r.sum  = col_acc[i];
            r.last = (i == n - 1);
            pending_sums.push_back(r);
        end
        i++;
        if (i >= n)
        begin
            i = 0;
            j++;
            if (j >= n)
                j = 0;
        end
        col_pos = i;
        row_pos = j;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : feed
        element_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                accumulate_column(matrix_value, vector_value);
                items_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (feed_q.size() == 0 ||
                         (feed_q[0].hold_drain && pending_sums.size() != 0))
                begin
                    in_valid <= 1'b0;
                end
                else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
                begin
                    gap_left = $urandom_range(16, 1) - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    nxt = feed_q.pop_front();
                    in_valid     <= 1'b1;
                    matrix_value <= nxt.matrix_v;
                    vector_value <= nxt.vector_v;
                end
            end
        end
    end

    task automatic flag_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : sink
        column_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_sums.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected item expected none actual index %0d sum %0d",
                             $time, column_index, column_sum);
                end
                else
                begin
                    want = pending_sums.pop_front();
                    flag_field("column_index", want.idx, column_index);
                    flag_field("column_sum", want.sum, column_sum);
                    flag_field("last_column", want.last, last_column);
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
            begin
                stall_left = $urandom_range(16, 1) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic elem_t pick_element();
        case ($urandom_range(7))
            0: return ELEM_MIN;
            1: return ELEM_MAX;
            2: return '0;
            3: return '1;
            default: return elem_t'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_pct();
        case ($urandom_range(3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 50;
        endcase
    endfunction

    task automatic offer(input elem_t m, input elem_t v, input bit hold);
        element_item_t it;
        it.matrix_v   = m;
        it.vector_v   = v;
        it.hold_drain = hold;
        feed_q.push_back(it);
        items_issued++;
    endtask

    task automatic queue_matrix(input int unsigned n, input bit ragged, input int unsigned drain_pct);
        elem_t row_v;
        for (int unsigned j = 0; j < n; j++)
        begin
            row_v = pick_element();
            for (int unsigned i = 0; i < n; i++)
                offer(pick_element(), ragged ? pick_element() : row_v,
                      $urandom_range(99) < drain_pct);
        end
    endtask

    task automatic settle();
        while (items_taken != items_issued || pending_sums.size() != 0 ||
               gap_left != 0 || stall_left != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_size(input logic [SRB-1:0] v);
        cfg_valid   <= 1'b1;
        size_in_use <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        size_reg = v;
        row_pos  = 0;
        col_pos  = 0;
    endtask

    initial
    begin
        int unsigned random_items;
        int unsigned n;
        int unsigned tail;
        logic [SRB-1:0] sz;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // At the reset size of 64 a partial matrix gives no result item.
        idle_pct  = 20;
        stall_pct = 20;
        for (int unsigned k = 0; k < NMAX + NMAX / 2; k++)
            offer((k % 2 == 0) ? ELEM_MIN : ELEM_MAX, ELEM_MIN, 1'b0);

        // Extreme values give the largest sums of the run.
        settle();
        load_size(SRB'(EXTREME_SIZE));
        for (int unsigned j = 0; j < EXTREME_SIZE; j++)
            for (int unsigned i = 0; i < EXTREME_SIZE; i++)
                offer((i % 2 == 0) ? ELEM_MIN : ELEM_MAX, ELEM_MIN, 1'b0);

        // A size of zero behaves as a one by one matrix.
        settle();
        load_size('0);
        offer(ELEM_MIN, ELEM_MIN, 1'b0);
        offer(ELEM_MAX, ELEM_MAX, 1'b0);
        offer(ELEM_MIN, ELEM_MAX, 1'b0);

        settle();
        load_size(SRB'(2));
        offer(ELEM_MAX, ELEM_MIN, 1'b0);
        offer('0, ELEM_MIN, 1'b0);
        offer('1, '1, 1'b0);
        offer(ELEM_MIN, '1, 1'b0);

        // An unfinished matrix is abandoned by a register write, which restarts the counters.
        settle();
        load_size(SRB'(3));
        for (int unsigned k = 0; k < 4; k++)
            offer(pick_element(), pick_element(), 1'b0);
        settle();
        load_size(SRB'(3));
        for (int unsigned k = 0; k < 9; k++)
            offer(pick_element(), pick_element(), k == 5);

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            settle();
            idle_pct  = pick_pct();
            stall_pct = pick_pct();
            case ($urandom_range(19))
                0:       sz = '0;
                1:       sz = SRB'(1);
                2:       sz = SRB'($urandom_range(32, 17));
                3, 4, 5: sz = SRB'($urandom_range(16, 9));
                default: sz = SRB'($urandom_range(8, 2));
            endcase
            load_size(sz);
            n = eff_size(sz);
            for (int unsigned r = (n > 16) ? 1 : $urandom_range(3, 1); r > 0; r--)
            begin
                queue_matrix(n, $urandom_range(9) == 0, 1);
                random_items += n * n;
            end
            if (n > 1 && $urandom_range(4) == 0)
            begin
                tail = $urandom_range(n * n - 1, 1);
                for (int unsigned k = 0; k < tail; k++)
                    offer(pick_element(), pick_element(), 1'b0);
                random_items += tail;
            end
        end

        // The closing part runs at full rate, including a size above the maximum.
        idle_pct  = 0;
        stall_pct = 0;
        settle();
        load_size('1);
        for (int unsigned k = 0; k < NMAX + 8; k++)
            offer(pick_element(), pick_element(), 1'b0);
        settle();
        load_size(SRB'(5));
        queue_matrix(5, 1'b0, 0);

        settle();
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### matrix_vector_column_sums.f
rtl/mvcs_pkg.sv
rtl/mvcs_cell.sv
rtl/mvcs_front.sv
rtl/matrix_vector_column_sums.sv
tb/sv/tb_top.sv
